/* design/tkl_pkg.sv */
// tkl_pkg: shared types and constants for the token lexer
// token kinds, error codes, character codes, queue sizing and the push bundle
// no dependencies
`default_nettype none

package tkl_pkg;

   typedef enum logic [3:0] {
      KIND_ASSIGN   = 4'd0,
      KIND_LBRACKET = 4'd1,
      KIND_RBRACKET = 4'd2,
      KIND_LPAREN   = 4'd3,
      KIND_RPAREN   = 4'd4,
      KIND_INT      = 4'd5,
      KIND_IDENT    = 4'd6,
      KIND_STRING   = 4'd7,
      KIND_TRUE     = 4'd8,
      KIND_FALSE    = 4'd9,
      KIND_NEWLINE  = 4'd10,
      KIND_COMMA    = 4'd11,
      KIND_COLON    = 4'd12,
      KIND_EOF      = 4'd13,
      KIND_ERROR    = 4'd14
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_EOT_STRING = 2'd1,
      ERR_UNEXPECTED = 2'd2
   } err_type;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam int KIND_W      = 4;
   localparam int ERR_W       = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

`default_nettype wire

/* design/tkl_scan.sv */
// tkl_scan: scanner state and per-byte token decode for the token lexer
// one byte per fire, up to two tokens per byte
// depends on tkl_pkg
`default_nettype none

module tkl_scan #(
   parameter int POSITION_BITS = 20,
   parameter int LINE_BITS     = 16
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      fire,
   input  wire  [7:0]                               text_byte,
   input  wire  [7:0]                               escape_char,
   output tkl_pkg::push_type                        push,
   output logic [2*POSITION_BITS+2*LINE_BITS+6:0]   tok0,
   output logic [2*POSITION_BITS+2*LINE_BITS+6:0]   tok1
);

   typedef enum logic [7:0] {
      MODE_IDLE  = 8'b0000_0001,
      MODE_CR    = 8'b0000_0010,
      MODE_COLON = 8'b0000_0100,
      MODE_STR   = 8'b0000_1000,
      MODE_ESC   = 8'b0001_0000,
      MODE_IDENT = 8'b0010_0000,
      MODE_INT   = 8'b0100_0000,
      MODE_HALT  = 8'b1000_0000
   } mode_type;

   localparam logic [3:0] KW_NONE     = 4'd0;
   localparam logic [3:0] KW_T        = 4'd1;
   localparam logic [3:0] KW_TR       = 4'd2;
   localparam logic [3:0] KW_TRU      = 4'd3;
   localparam logic [3:0] KW_TRUE     = 4'd4;
   localparam logic [3:0] KW_F        = 4'd5;
   localparam logic [3:0] KW_FA       = 4'd6;
   localparam logic [3:0] KW_FAL      = 4'd7;
   localparam logic [3:0] KW_FALS     = 4'd8;
   localparam logic [3:0] KW_FALSE    = 4'd9;

   localparam logic [31:0] WORD_TRUE  = "true";
   localparam logic [39:0] WORD_FALSE = "false";

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= "0") && (ch <= "9");
   endfunction

   function automatic logic is_ident_start(input logic [7:0] ch);
      return ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z")) ||
             (ch == tkl_pkg::CH_UNDER);
   endfunction

   // next keyword prefix state inside an identifier
   function automatic logic [3:0] kw_next(input logic [3:0] k, input logic [7:0] ch);
      logic [7:0] want;
      logic       ok;
      want = 8'h00;
      ok   = 1'b1;
      case (k)
         KW_T:    want = WORD_TRUE[23:16];
         KW_TR:   want = WORD_TRUE[15:8];
         KW_TRU:  want = WORD_TRUE[7:0];
         KW_F:    want = WORD_FALSE[31:24];
         KW_FA:   want = WORD_FALSE[23:16];
         KW_FAL:  want = WORD_FALSE[15:8];
         KW_FALS: want = WORD_FALSE[7:0];
         default: ok = 1'b0;
      endcase
      return (ok && (ch == want)) ? k + 4'd1 : KW_NONE;
   endfunction

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [LINE_BITS-1:0]     line_ff, line_in, col_ff, col_in;
   logic [3:0]               kw_ff, kw_in;

   logic [POSITION_BITS-1:0] pos_cons;
   logic [LINE_BITS-1:0]     line_cons, col_cons;
   logic                     is_lf;

   // scan from idle
   logic               i_cons, i_tok, i_start;
   tkl_pkg::kind_type  i_kind;
   tkl_pkg::err_type   i_err;
   mode_type           i_mode;
   logic [3:0]         i_kw;

   // pending and second token
   logic                     p_v, s_v, s_post;
   tkl_pkg::kind_type        p_kind, s_kind, word_kind;
   tkl_pkg::err_type         p_err, s_err;
   logic [POSITION_BITS-1:0] p_start, p_len, s_start, s_len, word_len;
   logic [LINE_BITS-1:0]     s_line, s_col;
   logic                     do_cons, restart, use_idle;

   assign is_lf     = (text_byte == tkl_pkg::CH_LF);
   assign pos_cons  = (pos_ff == '1) ? pos_ff : pos_ff + POSITION_BITS'(1);
   assign line_cons = (is_lf && (line_ff != '1)) ? line_ff + LINE_BITS'(1) : line_ff;
   assign col_cons  = is_lf ? LINE_BITS'(1) :
                      ((col_ff == '1) ? col_ff : col_ff + LINE_BITS'(1));
   assign word_len  = pos_ff - start_ff;

   always_comb begin
      if (mode_ff == MODE_INT) begin
         word_kind = tkl_pkg::KIND_INT;
      end else if (kw_ff == KW_TRUE) begin
         word_kind = tkl_pkg::KIND_TRUE;
      end else if (kw_ff == KW_FALSE) begin
         word_kind = tkl_pkg::KIND_FALSE;
      end else begin
         word_kind = tkl_pkg::KIND_IDENT;
      end
   end

   always_comb begin
      i_cons  = 1'b1;
      i_tok   = 1'b0;
      i_start = 1'b0;
      i_kind  = tkl_pkg::KIND_ERROR;
      i_err   = tkl_pkg::ERR_NONE;
      i_mode  = MODE_IDLE;
      i_kw    = kw_ff;
      unique case (text_byte) inside
         tkl_pkg::CH_SPACE, tkl_pkg::CH_TAB: begin
         end
         tkl_pkg::CH_CR: begin
            i_start = 1'b1;
            i_mode  = MODE_CR;
         end
         tkl_pkg::CH_LF: begin
            i_tok  = 1'b1;
            i_kind = tkl_pkg::KIND_NEWLINE;
         end
         tkl_pkg::CH_LPAREN: begin
            i_tok  = 1'b1;
            i_kind = tkl_pkg::KIND_LPAREN;
         end
         tkl_pkg::CH_RPAREN: begin
            i_tok  = 1'b1;
            i_kind = tkl_pkg::KIND_RPAREN;
         end
         tkl_pkg::CH_LBRACK: begin
            i_tok  = 1'b1;
            i_kind = tkl_pkg::KIND_LBRACKET;
         end
         tkl_pkg::CH_RBRACK: begin
            i_tok  = 1'b1;
            i_kind = tkl_pkg::KIND_RBRACKET;
         end
         tkl_pkg::CH_COMMA: begin
            i_tok  = 1'b1;
            i_kind = tkl_pkg::KIND_COMMA;
         end
         tkl_pkg::CH_COLON: begin
            i_start = 1'b1;
            i_mode  = MODE_COLON;
         end
         tkl_pkg::CH_DQUOTE: begin
            i_start = 1'b1;
            i_mode  = MODE_STR;
         end
         default: begin
            if (is_ident_start(text_byte)) begin
               i_start = 1'b1;
               i_mode  = MODE_IDENT;
               if (text_byte == WORD_TRUE[31:24]) begin
                  i_kw = KW_T;
               end else if (text_byte == WORD_FALSE[39:32]) begin
                  i_kw = KW_F;
               end else begin
                  i_kw = KW_NONE;
               end
            end else if (is_digit(text_byte)) begin
               i_start = 1'b1;
               i_mode  = MODE_INT;
            end else begin
               i_cons = 1'b0;
               i_tok  = 1'b1;
               i_kind = tkl_pkg::KIND_ERROR;
               i_err  = tkl_pkg::ERR_UNEXPECTED;
               i_mode = MODE_HALT;
            end
         end
      endcase
   end

   always_comb begin
      p_v      = 1'b0;
      p_kind   = word_kind;
      p_err    = tkl_pkg::ERR_NONE;
      p_start  = start_ff;
      p_len    = '0;
      s_v      = 1'b0;
      s_kind   = tkl_pkg::KIND_EOF;
      s_err    = tkl_pkg::ERR_NONE;
      s_start  = start_ff;
      s_len    = '0;
      s_post   = 1'b0;
      do_cons  = 1'b0;
      restart  = 1'b0;
      use_idle = 1'b0;
      mode_in  = mode_ff;
      start_in = start_ff;
      kw_in    = kw_ff;
      if (text_byte == tkl_pkg::CH_NUL) begin
         restart = 1'b1;
         s_v     = 1'b1;
         s_start = pos_ff;
         unique case (mode_ff) inside
            MODE_IDENT, MODE_INT: begin
               p_v   = 1'b1;
               p_len = word_len;
            end
            MODE_CR: begin
               p_v    = 1'b1;
               p_kind = tkl_pkg::KIND_NEWLINE;
            end
            MODE_COLON: begin
               p_v    = 1'b1;
               p_kind = tkl_pkg::KIND_COLON;
            end
            MODE_STR, MODE_ESC: begin
               p_v     = 1'b1;
               p_kind  = tkl_pkg::KIND_ERROR;
               p_err   = tkl_pkg::ERR_EOT_STRING;
               p_start = pos_ff;
               s_v     = 1'b0;
            end
            default: begin
            end
         endcase
      end else begin
         unique case (mode_ff)
            MODE_HALT: begin
            end
            MODE_STR: begin
               do_cons = 1'b1;
               if (text_byte == escape_char) begin
                  mode_in = MODE_ESC;
               end else if (text_byte == tkl_pkg::CH_DQUOTE) begin
                  mode_in = MODE_IDLE;
                  s_v     = 1'b1;
                  s_kind  = tkl_pkg::KIND_STRING;
                  s_len   = pos_cons - start_ff;
                  s_post  = 1'b1;
               end
            end
            MODE_ESC: begin
               do_cons = 1'b1;
               mode_in = MODE_STR;
            end
            MODE_CR: begin
               if (is_lf) begin
                  do_cons = 1'b1;
                  mode_in = MODE_IDLE;
                  s_v     = 1'b1;
                  s_kind  = tkl_pkg::KIND_NEWLINE;
                  s_post  = 1'b1;
               end else begin
                  p_v      = 1'b1;
                  p_kind   = tkl_pkg::KIND_NEWLINE;
                  use_idle = 1'b1;
               end
            end
            MODE_COLON: begin
               if (text_byte == tkl_pkg::CH_EQUALS) begin
                  do_cons = 1'b1;
                  mode_in = MODE_IDLE;
                  s_v     = 1'b1;
                  s_kind  = tkl_pkg::KIND_ASSIGN;
                  s_post  = 1'b1;
               end else begin
                  p_v      = 1'b1;
                  p_kind   = tkl_pkg::KIND_COLON;
                  use_idle = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_ident_start(text_byte) || is_digit(text_byte)) begin
                  do_cons = 1'b1;
                  kw_in   = kw_next(kw_ff, text_byte);
               end else begin
                  p_v      = 1'b1;
                  p_len    = word_len;
                  use_idle = 1'b1;
               end
            end
            MODE_INT: begin
               if (is_digit(text_byte)) begin
                  do_cons = 1'b1;
               end else begin
                  p_v      = 1'b1;
                  p_len    = word_len;
                  use_idle = 1'b1;
               end
            end
            MODE_IDLE: begin
               use_idle = 1'b1;
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
         if (use_idle) begin
            do_cons = i_cons;
            mode_in = i_mode;
            kw_in   = i_kw;
            s_v     = i_tok;
            s_kind  = i_kind;
            s_err   = i_err;
            s_start = pos_ff;
            s_post  = i_cons;
            if (i_start) begin
               start_in = pos_ff;
            end
         end
      end
      if (restart) begin
         mode_in  = MODE_IDLE;
         start_in = '0;
         kw_in    = KW_NONE;
         pos_in   = '0;
         line_in  = LINE_BITS'(1);
         col_in   = LINE_BITS'(1);
      end else if (do_cons) begin
         pos_in  = pos_cons;
         line_in = line_cons;
         col_in  = col_cons;
      end else begin
         pos_in  = pos_ff;
         line_in = line_ff;
         col_in  = col_ff;
      end
   end

   assign s_line = s_post ? line_cons : line_ff;
   assign s_col  = s_post ? col_cons : col_ff;

   assign push.first  = fire && (p_v || s_v);
   assign push.second = fire && p_v && s_v;

   assign tok1 = {1'b1, s_col, s_line, s_len, s_start, s_err, s_kind};
   assign tok0 = p_v ? {!s_v, col_ff, line_ff, p_len, p_start, p_err, p_kind} : tok1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         line_ff  <= LINE_BITS'(1);
         col_ff   <= LINE_BITS'(1);
         kw_ff    <= KW_NONE;
      end else if (fire) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         kw_ff    <= kw_in;
      end
   end

endmodule

`default_nettype wire

/* design/tkl_queue.sv */
// tkl_queue: small result queue taking up to two entries per cycle, giving one
// entries held in registers, head shown directly at the output
// depends on tkl_pkg
`default_nettype none

module tkl_queue #(
   parameter int WIDTH = 79
) (
   input  wire                              clock,
   input  wire                              reset,
   input  tkl_pkg::push_type                push,
   input  wire  [WIDTH-1:0]                 din0,
   input  wire  [WIDTH-1:0]                 din1,
   input  wire                              pop,
   output logic [WIDTH-1:0]                 dout,
   output logic [tkl_pkg::LEVEL_W-1:0]      level
);

   logic [WIDTH-1:0]              entry_ff [tkl_pkg::QUEUE_DEPTH];
   logic [tkl_pkg::PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [tkl_pkg::LEVEL_W-1:0]   level_ff, level_in;
   logic [tkl_pkg::PTR_W-1:0]     wr_next;

   assign wr_next  = wr_ff + tkl_pkg::PTR_W'(1);
   assign wr_in    = wr_ff + tkl_pkg::PTR_W'(push.first) + tkl_pkg::PTR_W'(push.second);
   assign rd_in    = rd_ff + tkl_pkg::PTR_W'(pop);
   assign level_in = level_ff + tkl_pkg::LEVEL_W'(push.first)
                   + tkl_pkg::LEVEL_W'(push.second) - tkl_pkg::LEVEL_W'(pop);

   assign dout  = entry_ff[rd_ff];
   assign level = level_ff;

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ff] <= din0;
      end
      if (push.second) begin
         entry_ff[wr_next] <= din1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

/* design/token_lexer_unit.sv */
// token_lexer_unit: top level of the streaming token lexer
// input register, escape register, scanner and result queue
// depends on tkl_pkg, tkl_scan, tkl_queue
`default_nettype none

// Takes source text one byte per beat and gives tokens on the rsp stream. A
// byte is held in an input register, decoded there by the scanner and its
// tokens (none, one or two) are written into a four-entry result queue whose
// head drives rsp. Bytes are taken at one per cycle as long as the queue has
// room for two more tokens; a byte that ends one token and starts another
// gives two result beats, so a sink taking one beat per cycle sees the input
// slowed only by those extra beats. rsp_tlast marks the last token of a byte.
// Byte 0 ends the text, gives the end token (an error token inside a string)
// and restarts position, line and column. The escape byte for strings is
// written through csr at any idle time.
module token_lexer_unit #(
   parameter int POSITION_BITS = 20,
   parameter int LINE_BITS     = 16
) (
   input  wire                                          clock,
   input  wire                                          reset,
   // req: text_byte
   input  wire                                          req_tvalid,
   output logic                                         req_tready,
   input  wire  [7:0]                                   req_tdata,
   // rsp tdata: token_start, token_length, line_after, column_after, zero pad
   output logic                                         rsp_tvalid,
   input  wire                                          rsp_tready,
   output logic [((2*POSITION_BITS+2*LINE_BITS+7)/8)*8-1:0] rsp_tdata,
   // rsp tuser: token_kind, error_kind
   output logic [5:0]                                   rsp_tuser,
   output logic                                         rsp_tlast,
   // csr: escape_char
   input  wire                                          csr_valid,
   output logic                                         csr_ready,
   input  wire  [7:0]                                   csr_data
);

   localparam int TOK_W   = 2*POSITION_BITS + 2*LINE_BITS + 7;
   localparam int FIELD_W = 2*POSITION_BITS + 2*LINE_BITS;
   localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

   logic                               in_valid_ff;
   logic [7:0]                         byte_ff;
   logic [7:0]                         escape_ff;
   logic                               fire;
   logic                               rsp_pop;
   tkl_pkg::push_type                  push;
   logic [TOK_W-1:0]                   tok0, tok1, head;
   logic [tkl_pkg::LEVEL_W-1:0]        rsp_level;

   assign fire       = in_valid_ff &&
                       (rsp_level <= tkl_pkg::LEVEL_W'(tkl_pkg::QUEUE_DEPTH - 2));
   assign req_tready = !in_valid_ff || fire;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         escape_ff   <= tkl_pkg::CH_APOS;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (csr_valid) begin
            escape_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   tkl_scan #(
      .POSITION_BITS (POSITION_BITS),
      .LINE_BITS     (LINE_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .text_byte   (byte_ff),
      .escape_char (escape_ff),
      .push        (push),
      .tok0        (tok0),
      .tok1        (tok1)
   );

   tkl_queue #(
      .WIDTH (TOK_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din0  (tok0),
      .din1  (tok1),
      .pop   (rsp_pop),
      .dout  (head),
      .level (rsp_level)
   );

   assign rsp_tvalid = (rsp_level != '0);
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign rsp_tuser  = head[tkl_pkg::KIND_W+tkl_pkg::ERR_W-1:0];
   assign rsp_tdata  = TDATA_W'(head[TOK_W-2:tkl_pkg::KIND_W+tkl_pkg::ERR_W]);
   assign rsp_tlast  = head[TOK_W-1];

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser[3:0] == tkl_pkg::KIND_ERROR) ==
                      (rsp_tuser[5:4] != tkl_pkg::ERR_NONE)))
      else $error("error kind disagrees with token kind");

   assert property (@(posedge clock) disable iff (reset)
      push.second |-> push.first)
      else $error("second token pushed without first");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted byte lost from input register");

   assert property (@(posedge clock) disable iff (reset)
      !reset |=> rsp_level == $past(rsp_level) + tkl_pkg::LEVEL_W'($past(push.first))
                 + tkl_pkg::LEVEL_W'($past(push.second))
                 - tkl_pkg::LEVEL_W'($past(rsp_pop)))
      else $error("result queue level out of step with beats");
`endif

endmodule

`default_nettype wire
